FILE: design/gtl_pkg.sv
`timescale 1ns / 1ps

package gtl_pkg;

   localparam logic [7:0] WORD_GAP_MAX = 8'd32;
   localparam logic [7:0] NBSP_CODE    = 8'd160;

   // Translation of one source byte: up to three Latin bytes, byte 0 first.
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      len;
      logic            consumed;
   } gtl_xlat_type;

   // Entry of the queue between the front and the back part.
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      len;
      logic            run_last;
      logic            text_end;
   } gtl_job_type;

   function automatic logic [7:0] gtl_up(input logic [7:0] c);
      logic [7:0] r;
      begin
         r = c;
         if ((c >= 8'hE1 && c <= 8'hF1) || (c >= 8'hF3 && c <= 8'hF9) ||
             (c >= 8'h61 && c <= 8'h7A)) begin
            r = c - 8'h20;
         end else begin
            case (c)
               8'hF2: r = 8'hD3;
               8'hDC: r = 8'hA2;
               8'hDD: r = 8'hB8;
               8'hDE: r = 8'hB9;
               8'hDF: r = 8'hBA;
               8'hFC: r = 8'hBC;
               8'hFD: r = 8'hBE;
               8'hFE: r = 8'hBF;
               8'hFA, 8'hC0: r = 8'hDA;
               8'hFB, 8'hE0: r = 8'hDB;
               default: r = c;
            endcase
         end
         return r;
      end
   endfunction

   function automatic logic [7:0] gtl_low(input logic [7:0] c);
      logic [7:0] r;
      begin
         r = c;
         if ((c >= 8'hC1 && c <= 8'hD1) || (c >= 8'hD3 && c <= 8'hD9) ||
             (c >= 8'h41 && c <= 8'h5A)) begin
            r = c + 8'h20;
         end else begin
            case (c)
               8'hA2: r = 8'hDC;
               8'hB8: r = 8'hDD;
               8'hB9: r = 8'hDE;
               8'hBA: r = 8'hDF;
               8'hBC: r = 8'hFC;
               8'hBE: r = 8'hFD;
               8'hBF: r = 8'hFE;
               8'hDA: r = 8'hFA;
               8'hDB: r = 8'hFB;
               default: r = c;
            endcase
         end
         return r;
      end
   endfunction

   // Single-letter table; bit 8 flags a hit.
   function automatic logic [8:0] gtl_simple(input logic [7:0] l);
      logic [8:0] r;
      begin
         case (l)
            8'hDC: r = {1'b1, "a"};
            8'hE2: r = {1'b1, "v"};
            8'hE4: r = {1'b1, "d"};
            8'hDD: r = {1'b1, "e"};
            8'hE6: r = {1'b1, "z"};
            8'hDE, 8'hE9, 8'hDF, 8'hFA, 8'hC0: r = {1'b1, "i"};
            8'hEA: r = {1'b1, "k"};
            8'hEB: r = {1'b1, "l"};
            8'hED: r = {1'b1, "n"};
            8'hEE: r = {1'b1, "x"};
            8'hFC, 8'hF9, 8'hFE: r = {1'b1, "o"};
            8'hF0: r = {1'b1, "p"};
            8'hF1: r = {1'b1, "r"};
            8'hF3, 8'hF2: r = {1'b1, "s"};
            8'hF4: r = {1'b1, "t"};
            8'hF5, 8'hFD, 8'hFB, 8'hE0: r = {1'b1, "y"};
            8'hF6: r = {1'b1, "f"};
            default: r = 9'd0;
         endcase
         return r;
      end
   endfunction

   function automatic logic gtl_voiced(input logic [7:0] c);
      logic r;
      begin
         case (c)
            8'hE2, 8'hE3, 8'hE4, 8'hE6, 8'hEB, 8'hEC, 8'hED, 8'hF1, 8'hE1,
            8'hDC, 8'hE5, 8'hDD, 8'hE7, 8'hDE, 8'hE9, 8'hDF, 8'hFA, 8'hC0,
            8'hEF, 8'hFC, 8'hF5, 8'hFD, 8'hFB, 8'hE0, 8'hF9, 8'hFE: r = 1'b1;
            default: r = 1'b0;
         endcase
         return r;
      end
   endfunction

   function automatic logic gtl_voiceless(input logic [7:0] c);
      logic r;
      begin
         case (c)
            8'hE8, 8'hEA, 8'hEE, 8'hF0, 8'hF3, 8'hF4, 8'hF6, 8'hF7, 8'hF8: r = 1'b1;
            default: r = 1'b0;
         endcase
         return r;
      end
   endfunction

   function automatic logic gtl_word_edge(input logic [7:0] c);
      return (c <= WORD_GAP_MAX) || (c == NBSP_CODE);
   endfunction

   function automatic gtl_xlat_type gtl_translate(input logic [7:0] cur,
                                                  input logic [7:0] nxt,
                                                  input logic [7:0] thd,
                                                  input logic [7:0] prv);
      gtl_xlat_type r;
      logic [8:0]   hit;
      logic [7:0]   l;
      logic [7:0]   n;
      logic [7:0]   t;
      logic [7:0]   p;
      logic         up1;
      logic         up2;
      logic         n_upsilon;
      begin
         l         = gtl_low(cur);
         n         = gtl_low(nxt);
         t         = gtl_low(thd);
         p         = gtl_low(prv);
         up1       = (gtl_up(cur) == cur);
         up2       = (gtl_up(nxt) == nxt);
         n_upsilon = (n == 8'hF5) || (n == 8'hFD);
         hit       = gtl_simple(l);
         r.bytes    = '0;
         r.bytes[0] = l;
         r.len      = 2'd1;
         r.consumed = 1'b0;
         if (hit[8]) begin
            r.bytes[0] = hit[7:0];
         end else if (l == 8'hE8) begin
            r.bytes[0] = "t";
            r.bytes[1] = "h";
            r.len      = 2'd2;
         end else if (l == 8'hF7) begin
            r.bytes[0] = "c";
            r.bytes[1] = "h";
            r.len      = 2'd2;
         end else if (l == 8'hF8) begin
            r.bytes[0] = "p";
            r.bytes[1] = "s";
            r.len      = 2'd2;
         end else if (l == 8'hE1 || l == 8'hE5 || l == 8'hE7) begin
            r.bytes[0] = (l == 8'hE1) ? "a" : ((l == 8'hE5) ? "e" : "i");
            if (n_upsilon && gtl_voiced(t)) begin
               r.bytes[1] = "v";
               r.len      = 2'd2;
               r.consumed = 1'b1;
            end else if (n_upsilon && gtl_voiceless(t)) begin
               r.bytes[1] = "f";
               r.len      = 2'd2;
               r.consumed = 1'b1;
            end
         end else if (l == 8'hE3) begin
            r.bytes[0] = "g";
            if (n == 8'hE3) begin
               r.bytes[0] = "n";
               r.bytes[1] = "g";
               r.len      = 2'd2;
               r.consumed = 1'b1;
            end else if (n == 8'hEE) begin
               r.bytes[0] = "n";
               r.bytes[1] = "x";
               r.len      = 2'd2;
               r.consumed = 1'b1;
            end else if (n == 8'hF7) begin
               r.bytes[0] = "n";
               r.bytes[1] = "c";
               r.bytes[2] = "h";
               r.len      = 2'd3;
               r.consumed = 1'b1;
            end
         end else if (l == 8'hEC) begin
            r.bytes[0] = "m";
            if (n == 8'hF0) begin
               r.consumed = 1'b1;
               if (gtl_word_edge(p) || gtl_word_edge(t)) begin
                  r.bytes[0] = "b";
               end else begin
                  r.bytes[1] = "p";
                  r.len      = 2'd2;
               end
            end
         end else if (l == 8'hEF) begin
            r.bytes[0] = "o";
            if (n_upsilon) begin
               r.bytes[1] = "u";
               r.len      = 2'd2;
               r.consumed = 1'b1;
            end
         end
         // A capital source letter raises the first byte; the rest follow
         // only when the next byte is not lowercase either.
         if (up1) begin
            r.bytes[0] = gtl_up(r.bytes[0]);
            if (up2) begin
               r.bytes[1] = gtl_up(r.bytes[1]);
               r.bytes[2] = gtl_up(r.bytes[2]);
            end
         end
         return r;
      end
   endfunction

endpackage

FILE: design/gtl_intf.sv
`timescale 1ns / 1ps

interface gtl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_text;

   modport source (output valid, output char_byte, output end_of_text, input ready);
   modport sink (input valid, input char_byte, input end_of_text, output ready);
endinterface

interface gtl_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       text_end;

   modport source (output valid, output out_byte, output run_last, output text_end,
                   input ready);
   modport sink (input valid, input out_byte, input run_last, input text_end,
                 output ready);
endinterface

FILE: design/gtl_front.sv
`timescale 1ns / 1ps

module gtl_front
   import gtl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   gtl_req_if.sink     req_if,
   input  logic        queue_full,
   output logic        push_valid,
   output gtl_job_type push_job
);

   logic [2:0][7:0] q_ff;
   logic [2:0][7:0] q_in;
   logic [1:0]      cnt_ff;
   logic [1:0]      cnt_in;
   logic            skip_ff;
   logic            skip_in;
   logic            flush_ff;
   logic            flush_in;
   logic [7:0]      prev_ff;
   logic [7:0]      prev_in;

   logic            work;
   logic            step;
   logic            accept;
   logic            skip_new;
   logic [1:0]      cnt_dec;
   logic [7:0]      nxt;
   logic [7:0]      thd;
   gtl_xlat_type    xlat;

   // Work is pending while a byte has full lookahead, a consumed partner
   // waits to be dropped, or the end of text is being flushed.
   assign work   = (cnt_ff == 2'd3) || ((skip_ff || flush_ff) && (cnt_ff != 2'd0));
   assign accept = req_if.valid && req_if.ready;
   assign step   = work && (skip_ff || !queue_full);

   assign req_if.ready = !work;

   assign nxt     = (cnt_ff > 2'd1) ? q_ff[1] : 8'd0;
   assign thd     = (cnt_ff > 2'd2) ? q_ff[2] : 8'd0;
   assign xlat    = gtl_translate(q_ff[0], nxt, thd, prev_ff);
   assign cnt_dec = cnt_ff - 2'd1;
   assign skip_new = skip_ff ? 1'b0 : xlat.consumed;

   always_comb begin
      push_valid        = step && !skip_ff;
      push_job.bytes    = xlat.bytes;
      push_job.len      = xlat.len;
      // During a flush the transaction ends with the last byte still to be
      // translated; otherwise each transaction translates at most one byte.
      push_job.run_last = flush_ff ? (cnt_dec == {1'b0, skip_new}) : 1'b1;
      push_job.text_end = flush_ff && (cnt_dec == {1'b0, skip_new});
   end

   always_comb begin
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      skip_in  = skip_ff;
      flush_in = flush_ff;
      prev_in  = prev_ff;
      if (step) begin
         q_in[0] = q_ff[1];
         q_in[1] = q_ff[2];
         cnt_in  = cnt_dec;
         prev_in = q_ff[0];
         skip_in = skip_new;
         if (flush_ff && (cnt_dec == 2'd0)) begin
            prev_in  = 8'd0;
            skip_in  = 1'b0;
            flush_in = 1'b0;
         end
      end else if (accept) begin
         case (cnt_ff)
            2'd0: q_in[0] = req_if.char_byte;
            2'd1: q_in[1] = req_if.char_byte;
            default: q_in[2] = req_if.char_byte;
         endcase
         cnt_in   = cnt_ff + 2'd1;
         flush_in = req_if.end_of_text;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         cnt_ff   <= 2'd0;
         skip_ff  <= 1'b0;
         flush_ff <= 1'b0;
         prev_ff  <= 8'd0;
      end else begin
         cnt_ff   <= cnt_in;
         skip_ff  <= skip_in;
         flush_ff <= flush_in;
         prev_ff  <= prev_in;
      end
   end

endmodule

FILE: design/gtl_queue.sv
`timescale 1ns / 1ps

module gtl_queue
   import gtl_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   input  gtl_job_type push_job,
   output logic        full,
   input  logic        pop,
   output logic        pop_valid,
   output gtl_job_type pop_job
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   gtl_job_type       entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = entries_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: design/gtl_back.sv
`timescale 1ns / 1ps

module gtl_back
   import gtl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   input  gtl_job_type job,
   output logic        pop,
   gtl_rsp_if.source   rsp_if
);

   gtl_job_type job_ff;
   gtl_job_type job_in;
   logic        busy_ff;
   logic        busy_in;
   logic [1:0]  idx_ff;
   logic [1:0]  idx_in;
   logic        out_valid_ff;
   logic        out_valid_in;
   logic [7:0]  out_byte_ff;
   logic [7:0]  out_byte_in;
   logic        run_last_ff;
   logic        run_last_in;
   logic        text_end_ff;
   logic        text_end_in;

   logic        out_free;
   logic        emit;
   logic        done;

   assign out_free = !out_valid_ff || rsp_if.ready;
   assign emit     = busy_ff && out_free;
   assign done     = emit && (idx_ff == job_ff.len - 2'd1);
   // The next job loads in the cycle the current one sends its last byte.
   assign pop      = job_valid && (!busy_ff || done);

   assign rsp_if.valid    = out_valid_ff;
   assign rsp_if.out_byte = out_byte_ff;
   assign rsp_if.run_last = run_last_ff;
   assign rsp_if.text_end = text_end_ff;

   always_comb begin
      job_in       = job_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      run_last_in  = run_last_ff;
      text_end_in  = text_end_ff;
      if (pop) begin
         job_in  = job;
         busy_in = 1'b1;
         idx_in  = 2'd0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + 2'd1;
      end
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = job_ff.bytes[idx_ff];
         run_last_in  = done && job_ff.run_last;
         text_end_in  = done && job_ff.text_end;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      idx_ff      <= idx_in;
      out_byte_ff <= out_byte_in;
      run_last_ff <= run_last_in;
      text_end_ff <= text_end_in;
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

FILE: design/greek_to_latin_transliterator.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                           Handshake
// req_if    in   char_byte[7:0], end_of_text       valid / ready
// rsp_if    out  out_byte[7:0], run_last, text_end valid / ready
//
// The front accepts a source byte and, once its lookahead is full, translates
// or drops a held byte before it accepts another; a flush translates all held
// bytes. While not stalled, the back sends one Latin byte per cycle, one to
// three for each translated byte. No rule gives more than two Latin bytes per
// source byte on average, so without stalls the front sets the rate.
// Reset is synchronous and clears the lookahead state, the job queue and the
// output register.
// Either side may stall; the job queue and the output register decouple them.

module greek_to_latin_transliterator
   import gtl_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic      clock,
   input  logic      reset,
   gtl_req_if.sink   req_if,
   gtl_rsp_if.source rsp_if
);

   logic        push_valid;
   gtl_job_type push_job;
   logic        queue_full;
   logic        pop;
   logic        pop_valid;
   gtl_job_type pop_job;

   gtl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   gtl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job)
   );

   gtl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job       (pop_job),
      .pop       (pop),
      .rsp_if    (rsp_if)
   );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int TAIL_CYCLES  = 40;
   localparam int RANDOM_ITEMS = 440;
   localparam int MAX_REPORTS  = 10;

   // Letters that take part in the pair rules, and the space code.
   localparam logic [7:0] GAMMA         = 8'hE3;
   localparam logic [7:0] XI            = 8'hEE;
   localparam logic [7:0] CHI           = 8'hF7;
   localparam logic [7:0] MU            = 8'hEC;
   localparam logic [7:0] PI            = 8'hF0;
   localparam logic [7:0] OMICRON       = 8'hEF;
   localparam logic [7:0] UPSILON       = 8'hF5;
   localparam logic [7:0] UPSILON_TONOS = 8'hFD;
   localparam logic [7:0] SPACE         = 8'h20;

   localparam logic [27*8-1:0] PLAIN_SRC = {
      8'hDC, 8'hE2, 8'hE4, 8'hDD, 8'hE6, 8'hDE, 8'hE9, 8'hDF, 8'hFA, 8'hC0,
      8'hEA, 8'hEB, 8'hED, 8'hEE, 8'hFC, 8'hF0, 8'hF1, 8'hF3, 8'hF2, 8'hF4,
      8'hF5, 8'hFD, 8'hFB, 8'hE0, 8'hF6, 8'hF9, 8'hFE};
   localparam logic [27*8-1:0] PLAIN_DST = "avdeziiiiiklnxoprsstyyyyfoo";
   localparam logic [3*8-1:0]  PAIR_SRC  = {8'hE8, 8'hF7, 8'hF8};
   localparam logic [6*8-1:0]  PAIR_DST  = "thchps";
   localparam logic [3*8-1:0]  VOWEL_SRC = {8'hE1, 8'hE5, 8'hE7};
   localparam logic [3*8-1:0]  VOWEL_DST = "aei";
   localparam logic [26*8-1:0] VOICED    = {
      8'hE2, 8'hE3, 8'hE4, 8'hE6, 8'hEB, 8'hEC, 8'hED, 8'hF1, 8'hE1, 8'hDC,
      8'hE5, 8'hDD, 8'hE7, 8'hDE, 8'hE9, 8'hDF, 8'hFA, 8'hC0, 8'hEF, 8'hFC,
      8'hF5, 8'hFD, 8'hFB, 8'hE0, 8'hF9, 8'hFE};
   localparam logic [9*8-1:0]  VOICELESS = {
      8'hE8, 8'hEA, 8'hEE, 8'hF0, 8'hF3, 8'hF4, 8'hF6, 8'hF7, 8'hF8};

   typedef struct {
      logic [7:0] ch;
      logic       eot;
      bit         hold_off;
   } greek_item_type;

   typedef struct {
      logic [7:0] out_byte;
      logic       run_last;
      logic       text_end;
   } latin_byte_type;

   typedef struct {
      logic [2:0][7:0] latin;
      int              count;
      bit              eats_next;
   } latin_run_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gtl_req_if req_if ();
   gtl_rsp_if rsp_if ();

   greek_to_latin_transliterator u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   greek_item_type greek_text [$];
   logic [7:0]     text_buf [$];
   latin_byte_type latin_expected [$];

   // Transliterator state as seen by the predictor.
   logic [7:0] prev_src = 8'd0;
   logic [7:0] held [2] = '{8'd0, 8'd0};
   int         held_n = 0;
   bit         drop_next = 1'b0;

   int   total_items = 0;
   int   items_loaded = 0;
   int   fail_count = 0;
   int   cycle_count = 0;
   logic results_drained = 1'b1;
   logic calm;

   // A stretch of the run in which neither side draws random idle cycles.
   assign calm = (items_loaded >= 200) && (items_loaded < 320);

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if ((c >= 8'hE1 && c <= 8'hF1) || (c >= 8'hF3 && c <= 8'hF9) ||
          (c >= "a" && c <= "z")) begin
         r = c - 8'h20;
      end else begin
         case (c)
            8'hF2:        r = 8'hD3;
            8'hDC:        r = 8'hA2;
            8'hDD:        r = 8'hB8;
            8'hDE:        r = 8'hB9;
            8'hDF:        r = 8'hBA;
            8'hFC:        r = 8'hBC;
            8'hFD:        r = 8'hBE;
            8'hFE:        r = 8'hBF;
            8'hFA, 8'hC0: r = 8'hDA;
            8'hFB, 8'hE0: r = 8'hDB;
            default:      r = c;
         endcase
      end
      return r;
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if ((c >= 8'hC1 && c <= 8'hD1) || (c >= 8'hD3 && c <= 8'hD9) ||
          (c >= "A" && c <= "Z")) begin
         r = c + 8'h20;
      end else begin
         case (c)
            8'hA2:   r = 8'hDC;
            8'hB8:   r = 8'hDD;
            8'hB9:   r = 8'hDE;
            8'hBA:   r = 8'hDF;
            8'hBC:   r = 8'hFC;
            8'hBE:   r = 8'hFD;
            8'hBF:   r = 8'hFE;
            8'hDA:   r = 8'hFA;
            8'hDB:   r = 8'hFB;
            default: r = c;
         endcase
      end
      return r;
   endfunction

   // Entries sit in the low count bytes of the vector, first entry highest.
   function automatic int slot_of(input logic [27*8-1:0] set, input int count,
                                  input logic [7:0] c);
      for (int i = 0; i < count; i++) begin
         if (set[(count - 1 - i) * 8 +: 8] == c) return i;
      end
      return -1;
   endfunction

   function automatic bit word_gap(input logic [7:0] c);
      return (c <= gtl_pkg::WORD_GAP_MAX) || (c == gtl_pkg::NBSP_CODE);
   endfunction

   function automatic latin_run_type transliterate(input logic [7:0] cur,
                                                   input logic [7:0] nxt,
                                                   input logic [7:0] thd,
                                                   input logic [7:0] prv);
      latin_run_type r;
      logic [7:0] l;
      logic [7:0] n;
      logic [7:0] t;
      logic [7:0] p;
      int         k_plain;
      int         k_pair;
      int         k_vowel;
      bit         upsilon_next;
      l            = to_lower(cur);
      n            = to_lower(nxt);
      t            = to_lower(thd);
      p            = to_lower(prv);
      upsilon_next = (n == UPSILON) || (n == UPSILON_TONOS);
      k_plain      = slot_of(PLAIN_SRC, 27, l);
      k_pair       = slot_of(PAIR_SRC, 3, l);
      k_vowel      = slot_of(VOWEL_SRC, 3, l);
      r.latin      = '0;
      r.latin[0]   = l;
      r.count      = 1;
      r.eats_next  = 1'b0;
      if (k_plain >= 0) begin
         r.latin[0] = PLAIN_DST[(26 - k_plain) * 8 +: 8];
      end else if (k_pair >= 0) begin
         r.latin[0] = PAIR_DST[(5 - 2 * k_pair) * 8 +: 8];
         r.latin[1] = PAIR_DST[(4 - 2 * k_pair) * 8 +: 8];
         r.count    = 2;
      end else if (k_vowel >= 0) begin
         r.latin[0] = VOWEL_DST[(2 - k_vowel) * 8 +: 8];
         if (upsilon_next && slot_of(VOICED, 26, t) >= 0) begin
            r.latin[1]  = "v";
            r.count     = 2;
            r.eats_next = 1'b1;
         end else if (upsilon_next && slot_of(VOICELESS, 9, t) >= 0) begin
            r.latin[1]  = "f";
            r.count     = 2;
            r.eats_next = 1'b1;
         end
      end else if (l == GAMMA) begin
         r.latin[0] = "g";
         if (n == GAMMA || n == XI || n == CHI) begin
            r.latin[0]  = "n";
            r.count     = 2;
            r.eats_next = 1'b1;
            if (n == GAMMA) begin
               r.latin[1] = "g";
            end else if (n == XI) begin
               r.latin[1] = "x";
            end else begin
               r.latin[1] = "c";
               r.latin[2] = "h";
               r.count    = 3;
            end
         end
      end else if (l == MU) begin
         r.latin[0] = "m";
         if (n == PI) begin
            r.eats_next = 1'b1;
            if (word_gap(p) || word_gap(t)) begin
               r.latin[0] = "b";
            end else begin
               r.latin[1] = "p";
               r.count    = 2;
            end
         end
      end else if (l == OMICRON) begin
         r.latin[0] = "o";
         if (upsilon_next) begin
            r.latin[1]  = "u";
            r.count     = 2;
            r.eats_next = 1'b1;
         end
      end
      // The source case decides the first byte; with a capital source, the next byte decides the rest.
      if (to_upper(cur) == cur) begin
         r.latin[0] = to_upper(r.latin[0]);
         if (to_upper(nxt) == nxt) begin
            r.latin[1] = to_upper(r.latin[1]);
            r.latin[2] = to_upper(r.latin[2]);
         end
      end
      return r;
   endfunction

   // Translates every byte whose lookahead is complete, or all of them at the
   // end of the text, and queues the Latin bytes this transaction causes.
   task automatic predict_latin(input logic [7:0] ch, input logic eot);
      logic [7:0]     win [3];
      int             n;
      int             i;
      latin_run_type  run;
      latin_byte_type batch [$];
      latin_byte_type item;
      win[0] = held[0];
      win[1] = held[1];
      win[2] = 8'd0;
      n = held_n;
      win[n] = ch;
      n++;
      while (n > 0) begin
         if (!drop_next && n < 3 && !eot) break;
         if (drop_next) begin
            drop_next = 1'b0;
         end else begin
            run = transliterate(win[0], (n > 1) ? win[1] : 8'd0,
                                (n > 2) ? win[2] : 8'd0, prev_src);
            for (i = 0; i < run.count; i++) begin
               item.out_byte = run.latin[i];
               item.run_last = 1'b0;
               item.text_end = 1'b0;
               batch.push_back(item);
            end
            if (run.eats_next) drop_next = 1'b1;
         end
         prev_src = win[0];
         win[0] = win[1];
         win[1] = win[2];
         n--;
      end
      if (eot) begin
         prev_src  = 8'd0;
         drop_next = 1'b0;
         n = 0;
      end
      held[0] = (n > 0) ? win[0] : 8'd0;
      held[1] = (n > 1) ? win[1] : 8'd0;
      held_n  = n;
      for (i = 0; i < batch.size(); i++) begin
         item = batch[i];
         if (i == batch.size() - 1) begin
            item.run_last = 1'b1;
            item.text_end = eot;
         end
         latin_expected.push_back(item);
      end
   endtask

   // Copies text_buf into the send queue as one text, closed by end of text.
   task automatic queue_text(input bit hold_first);
      greek_item_type g;
      for (int i = 0; i < text_buf.size(); i++) begin
         g.ch       = text_buf[i];
         g.eot      = (i == text_buf.size() - 1);
         g.hold_off = (hold_first && i == 0) || ($urandom_range(0, 149) == 0);
         greek_text.push_back(g);
      end
   endtask

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("%s", msg);
   endtask

   // Driver: presents the next source byte once the previous transaction is gone.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (greek_text.size() > 0 && (calm || $urandom_range(0, 99) >= 25) &&
             (!greek_text[0].hold_off || (!req_if.valid && results_drained))) begin
            req_if.valid       <= 1'b1;
            req_if.char_byte   <= greek_text[0].ch;
            req_if.end_of_text <= greek_text[0].eot;
            void'(greek_text.pop_front());
            items_loaded <= items_loaded + 1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Monitor: predicts on each accepted source byte, checks each Latin byte.
   always @(posedge clock) begin
      latin_byte_type want;
      if (reset) begin
         rsp_if.ready    <= 1'b0;
         results_drained <= 1'b1;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_latin(req_if.char_byte, req_if.end_of_text);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (latin_expected.size() == 0) begin
               note_failure($sformatf("unexpected byte %02h last %0b end %0b",
                                      rsp_if.out_byte, rsp_if.run_last, rsp_if.text_end));
            end else begin
               want = latin_expected.pop_front();
               if (rsp_if.out_byte !== want.out_byte || rsp_if.run_last !== want.run_last ||
                   rsp_if.text_end !== want.text_end) begin
                  note_failure($sformatf(
                     "mismatch: expected byte %02h last %0b end %0b, got %02h %0b %0b",
                     want.out_byte, want.run_last, want.text_end,
                     rsp_if.out_byte, rsp_if.run_last, rsp_if.text_end));
               end
            end
         end
         results_drained <= (latin_expected.size() == 0);
         rsp_if.ready    <= calm || ($urandom_range(0, 99) >= 25);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int         random_count;
      int         len;
      int         mode;
      int         r;
      bit         first_random;
      req_if.valid       = 1'b0;
      req_if.char_byte   = 8'd0;
      req_if.end_of_text = 1'b0;
      rsp_if.ready       = 1'b0;

      // Directed texts: zero and all-ones bytes, mu-pi at the start of a text,
      // vowel-upsilon before voiceless and voiced letters, capitals on both
      // sides, the three gamma pairs, digraphs, omicron-upsilon with tonos,
      // mu-pi after a no-break space, and upsilon with no third letter.
      text_buf = '{8'h00};
      queue_text(1'b0);
      text_buf = '{8'hFF};
      queue_text(1'b0);
      text_buf = '{MU, PI, 8'hE1};
      queue_text(1'b0);
      text_buf = '{8'hE1, UPSILON, 8'hF4, 8'hF8};
      queue_text(1'b0);
      text_buf = '{8'hC5, 8'hD5, 8'hC1};
      queue_text(1'b0);
      text_buf = '{GAMMA, GAMMA, 8'hC3, XI, GAMMA, CHI};
      queue_text(1'b0);
      text_buf = '{8'hE8, OMICRON, UPSILON_TONOS};
      queue_text(1'b0);
      text_buf = '{gtl_pkg::NBSP_CODE, MU, PI, 8'hE1, UPSILON};
      queue_text(1'b0);

      // Random texts: mostly Greek words rich in pairs, with gaps and noise.
      random_count = 0;
      first_random = 1'b1;
      while (random_count < RANDOM_ITEMS) begin
         text_buf.delete();
         len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 16);
         mode = $urandom_range(0, 2);
         while (text_buf.size() < len) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
               case ($urandom_range(0, 3))
                  0:       text_buf.push_back(SPACE);
                  1:       text_buf.push_back(gtl_pkg::NBSP_CODE);
                  2:       text_buf.push_back(8'h00);
                  default: text_buf.push_back(8'($urandom_range(0, 32)));
               endcase
            end else if (r < 22) begin
               text_buf.push_back(8'($urandom_range(0, 255)));
            end else if (r < 50) begin
               case ($urandom_range(0, 3))
                  0: begin
                     text_buf.push_back(VOWEL_SRC[$urandom_range(0, 2) * 8 +: 8]);
                     text_buf.push_back($urandom_range(0, 1) ? UPSILON : UPSILON_TONOS);
                  end
                  1: begin
                     text_buf.push_back(GAMMA);
                     case ($urandom_range(0, 2))
                        0:       text_buf.push_back(GAMMA);
                        1:       text_buf.push_back(XI);
                        default: text_buf.push_back(CHI);
                     endcase
                  end
                  2: begin
                     text_buf.push_back(MU);
                     text_buf.push_back(PI);
                  end
                  default: begin
                     text_buf.push_back(OMICRON);
                     text_buf.push_back($urandom_range(0, 1) ? UPSILON : UPSILON_TONOS);
                  end
               endcase
            end else if (r < 90) begin
               text_buf.push_back(8'($urandom_range(8'hE1, 8'hFE)));
            end else begin
               text_buf.push_back(8'($urandom_range(8'hDC, 8'hE0)));
            end
         end
         // Mode 0 keeps lowercase, mode 1 raises some letters, mode 2 all.
         for (int i = 0; i < text_buf.size(); i++) begin
            if (mode == 2 || (mode == 1 && $urandom_range(0, 2) == 0)) begin
               text_buf[i] = to_upper(text_buf[i]);
            end
         end
         queue_text(first_random);
         first_random = 1'b0;
         random_count += text_buf.size();
      end
      total_items = greek_text.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (!(items_loaded == total_items && !req_if.valid && results_drained)) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      #1;
      if (latin_expected.size() > 0) begin
         note_failure($sformatf("%0d expected bytes never arrived", latin_expected.size()));
      end
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
